/* design/relr_pkg.sv */
// shared types and constants for the relr relocation decoder
package relr_pkg;

   // widths fixed by the table format
   localparam int ENTRY_W     = 64;
   localparam int BITMAP_W    = 63;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // one decoded command between front and back
   typedef struct packed {
      logic [BITMAP_W-1:0] bits;  // bit i set: emit base + i words
      logic [ENTRY_W-1:0]  base;  // address of bit 0
   } relr_cmd_type;

   // transfer group for the command queue
   typedef struct packed {
      logic         valid;
      relr_cmd_type cmd;
   } relr_cmd_xfer_type;

endpackage

/* design/relr_front.sv */
// front end: accepts table entries, tracks the next address, emits commands
module relr_front #(
   parameter int WORD_BYTES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [relr_pkg::ENTRY_W-1:0] req_tdata,
   input  logic                       req_tlast,
   output relr_pkg::relr_cmd_xfer_type push,
   input  logic                       push_ready
);

   localparam int ENTRY_BITS = 8 * WORD_BYTES;
   localparam logic [relr_pkg::ENTRY_W-1:0] ADDR_MASK =
      {relr_pkg::ENTRY_W{1'b1}} >> (relr_pkg::ENTRY_W - ENTRY_BITS);
   localparam logic [relr_pkg::ENTRY_W-1:0] WORD_STEP = relr_pkg::ENTRY_W'(WORD_BYTES);
   localparam logic [relr_pkg::ENTRY_W-1:0] BITMAP_STEP =
      relr_pkg::ENTRY_W'((ENTRY_BITS - 1) * WORD_BYTES);

   logic [relr_pkg::ENTRY_W-1:0] next_addr_ff;
   logic [relr_pkg::ENTRY_W-1:0] next_addr_in;
   logic [relr_pkg::ENTRY_W-1:0] word;
   logic                         accept;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign word       = req_tdata & ADDR_MASK;

   // classify the entry and build the command
   always_comb begin
      push.valid = accept;
      if (!word[0]) begin
         push.cmd.base = word;
         push.cmd.bits = relr_pkg::BITMAP_W'(1);
         next_addr_in  = (word + WORD_STEP) & ADDR_MASK;
      end else begin
         push.cmd.base = next_addr_ff;
         push.cmd.bits = word[relr_pkg::ENTRY_W-1:1];
         next_addr_in  = (next_addr_ff + BITMAP_STEP) & ADDR_MASK;
      end
      if (req_tlast) begin
         next_addr_in = '0;
      end
   end

   // next address register
   always_ff @(posedge clock) begin
      if (reset) begin
         next_addr_ff <= '0;
      end else if (accept) begin
         next_addr_ff <= next_addr_in;
      end
   end

endmodule

/* design/relr_cmd_queue.sv */
// two-entry command queue between front and back
module relr_cmd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  relr_pkg::relr_cmd_xfer_type push,
   output logic                        push_ready,
   output relr_pkg::relr_cmd_xfer_type head,
   input  logic                        pop
);

   relr_pkg::relr_cmd_type               slot_ff [relr_pkg::QUEUE_DEPTH];
   logic [relr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [relr_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [relr_pkg::QUEUE_CNT_W-1:0]     count_ff;
   logic [relr_pkg::QUEUE_CNT_W-1:0]     count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign push_ready = (count_ff != relr_pkg::QUEUE_CNT_W'(relr_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && head.valid;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

/* design/relr_back.sv */
// back end: walks a command bit by bit and drives the result register
module relr_back #(
   parameter int WORD_BYTES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  relr_pkg::relr_cmd_xfer_type   head,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [relr_pkg::ENTRY_W-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int ENTRY_BITS = 8 * WORD_BYTES;
   localparam logic [relr_pkg::ENTRY_W-1:0] ADDR_MASK =
      {relr_pkg::ENTRY_W{1'b1}} >> (relr_pkg::ENTRY_W - ENTRY_BITS);
   localparam logic [relr_pkg::ENTRY_W-1:0] WORD_STEP = relr_pkg::ENTRY_W'(WORD_BYTES);

   logic                          busy_ff;
   logic                          busy_in;
   logic [relr_pkg::BITMAP_W-1:0] bits_ff;
   logic [relr_pkg::BITMAP_W-1:0] bits_in;
   logic [relr_pkg::ENTRY_W-1:0]  addr_ff;
   logic [relr_pkg::ENTRY_W-1:0]  addr_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [relr_pkg::ENTRY_W-1:0]  out_addr_ff;
   logic                          out_last_ff;
   logic [relr_pkg::BITMAP_W-1:0] rest;
   logic                          out_free;
   logic                          emit;
   logic                          advance;

   assign rest     = bits_ff >> 1;
   assign out_free = !out_valid_ff || rsp_tready;
   assign emit     = busy_ff && bits_ff[0] && out_free;
   assign advance  = busy_ff && (out_free || !bits_ff[0]);
   assign pop      = !busy_ff && head.valid;

   // walk: load a command when idle, one bit per cycle unless held
   always_comb begin
      busy_in = busy_ff;
      bits_in = bits_ff;
      addr_in = addr_ff;
      if (pop) begin
         busy_in = |head.cmd.bits;
         bits_in = head.cmd.bits;
         addr_in = head.cmd.base;
      end else if (advance) begin
         busy_in = |rest;
         bits_in = rest;
         addr_in = (addr_ff + WORD_STEP) & ADDR_MASK;
      end
   end

   // result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      addr_ff <= addr_in;
      if (emit) begin
         out_addr_ff <= addr_ff;
         out_last_ff <= ~|rest;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_addr_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* design/relr_relocation_decoder_top.sv */
// top level of the relr relative-relocation address decoder
//
// usage: feed packed relr table words on the req_ stream, one word per
// transfer, with req_tlast high on the final word of a table. the rsp_
// stream gives one patch address per transfer; rsp_tlast is high on the
// last address produced by a given table word. a bitmap word with no bits
// set above bit 0 produces nothing but still advances the running address.
// an accepted word passes through the queue into the walk registers; its
// first address reaches the result register after the back end steps over
// each clear bitmap position below the lowest set one. the back end steps
// one bitmap position per cycle, holding at a set one while the result
// register is full, and pops a word only when done with the last. the front
// end takes new words into a two-entry queue while the back end works.
// reset clears the running address to zero and empties the queue and the
// result register. when rsp_tready is low the result register holds, the
// back end halts at a set bit, and once the queue fills req_tready drops.
module relr_relocation_decoder_top #(
   parameter int WORD_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // entry[63:0]
   input  logic        req_tlast,   // end_of_table
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // patch_address[63:0]
   output logic        rsp_tlast    // last_of_run
);

   relr_pkg::relr_cmd_xfer_type push;
   relr_pkg::relr_cmd_xfer_type head;
   logic                        push_ready;
   logic                        pop;

   // entry classification and running address
   relr_front #(
      .WORD_BYTES (WORD_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_ready (push_ready)
   );

   // decoupling queue
   relr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   // bitmap walk and result register
   relr_back #(
      .WORD_BYTES (WORD_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/relr_relocation_decoder_top_tb.sv */
// self-checking testbench for the relr relocation decoder top level
module relr_relocation_decoder_top_tb;

   localparam int ENTRY_W     = relr_pkg::ENTRY_W;
   localparam int WORD_BYTES  = 8;
   localparam int ENTRY_BITS  = 8 * WORD_BYTES;
   localparam logic [ENTRY_W-1:0] ADDR_MASK = {ENTRY_W{1'b1}} >> (ENTRY_W - ENTRY_BITS);
   localparam int MAX_REPORTS = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 48;

   // bit 0 of a table word says how the rest is read
   typedef enum logic {
      WORD_ADDRESS = 1'b0,
      WORD_BITMAP  = 1'b1
   } word_kind_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] patch_address;
      logic               last_of_run;
   } patch_type;

   // one table word; typed rows carry a hand-worked first address and count
   typedef struct packed {
      logic [ENTRY_W-1:0] entry;
      logic               end_of_table;
      logic               typed;
      logic [6:0]         count;
      logic [ENTRY_W-1:0] first;
   } word_row_type;

   localparam word_row_type DIRECTED_ROWS [18] = '{
      '{64'h0000_0000_0000_0000, 1'b0, 1'b1, 7'd1,  64'h0000_0000_0000_0000},
      '{64'h0000_0000_0000_0003, 1'b0, 1'b1, 7'd1,  64'h0000_0000_0000_0008},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 7'd63, 64'h0000_0000_0000_0200},
      '{64'h0000_0000_0000_0001, 1'b0, 1'b1, 7'd0,  64'h0000_0000_0000_0000},
      '{64'h8000_0000_0000_0001, 1'b0, 1'b1, 7'd1,  64'h0000_0000_0000_07E0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1, 7'd1,  64'hFFFF_FFFF_FFFF_FFFE},
      '{64'h0000_0000_0000_0005, 1'b0, 1'b1, 7'd1,  64'h0000_0000_0000_000E},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 7'd1,  64'hAAAA_AAAA_AAAA_AAAA},
      '{64'h0000_0000_0000_0003, 1'b0, 1'b1, 7'd1,  64'h0000_0000_0000_0000},
      '{64'h5555_5555_5555_5555, 1'b1, 1'b0, 7'd0,  64'h0000_0000_0000_0000},
      '{64'hAAAA_AAAA_AAAA_AAAB, 1'b0, 1'b1, 7'd32, 64'h0000_0000_0000_0000},
      '{64'h0000_0000_0000_0001, 1'b1, 1'b1, 7'd0,  64'h0000_0000_0000_0000},
      '{64'h7FFF_FFFF_FFFF_FFF8, 1'b0, 1'b1, 7'd1,  64'h7FFF_FFFF_FFFF_FFF8},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 7'd0,  64'h0000_0000_0000_0000},
      '{64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b1, 7'd1,  64'hFFFF_FFFF_FFFF_FF00},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 7'd0,  64'h0000_0000_0000_0000},
      '{64'h0000_0000_0000_0002, 1'b1, 1'b1, 7'd1,  64'h0000_0000_0000_0002},
      '{64'h4000_0000_0000_0001, 1'b0, 1'b1, 7'd1,  64'h0000_0000_0000_01E8}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // entry[63:0]
   logic        req_tlast  = 1'b0; // end_of_table
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // patch_address[63:0]
   logic        rsp_tlast;         // last_of_run

   // predictor state and scoreboard
   logic [ENTRY_W-1:0] run_address = '0;
   patch_type          pending_patches[$];
   word_row_type       row_checks[$];

   int idle_pct        = 0;
   int stall_pct       = 0;
   int mismatches      = 0;
   int cycles          = 0;
   int words_sent      = 0;
   int address_words   = 0;
   int bitmap_words    = 0;
   int empty_bitmaps   = 0;
   int table_ends      = 0;
   int patches_checked = 0;

   relr_relocation_decoder_top #(
      .WORD_BYTES(WORD_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #2 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d patch addresses outstanding",
                  cycles, pending_patches.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void report_mismatch(input string what, input string detail);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s: %s", cycles, what, detail);
   endfunction

   // expands one table word into its patch addresses and advances the run address
   function automatic int decode_entry(input logic [ENTRY_W-1:0] raw, input logic eot);
      logic [ENTRY_W-1:0] word;
      logic [ENTRY_W-1:0] addr;
      int                 top;
      int                 n;
      word = raw & ADDR_MASK;
      n    = 0;
      top  = 0;
      if (word[0] == WORD_ADDRESS) begin
         pending_patches.push_back('{word, 1'b1});
         n           = 1;
         run_address = (word + ENTRY_W'(WORD_BYTES)) & ADDR_MASK;
      end else begin
         for (int j = 1; j < ENTRY_BITS; j++)
            if (word[j]) top = j;
         for (int j = 1; j < ENTRY_BITS; j++) begin
            if (word[j]) begin
               addr = (run_address + ENTRY_W'(j - 1) * ENTRY_W'(WORD_BYTES)) & ADDR_MASK;
               pending_patches.push_back('{addr, j == top});
               n++;
            end
         end
         run_address = (run_address + ENTRY_W'(ENTRY_BITS - 1) * ENTRY_W'(WORD_BYTES))
                       & ADDR_MASK;
      end
      if (eot) run_address = '0;
      return n;
   endfunction

   // result checking, prediction on accepted words, and receiver stalls
   always @(posedge clock) begin : watch
      patch_type    got;
      patch_type    want;
      word_row_type row;
      int           base;
      int           n;
      if (!reset) begin
         // compare each result transfer with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tlast};
            if (pending_patches.size() == 0) begin
               report_mismatch("unexpected patch",
                               $sformatf("got addr %h last %b", got.patch_address,
                                         got.last_of_run));
            end else begin
               want = pending_patches.pop_front();
               patches_checked++;
               if (got.patch_address !== want.patch_address ||
                   got.last_of_run !== want.last_of_run)
                  report_mismatch("patch",
                                  $sformatf("want addr %h last %b, got addr %h last %b",
                                            want.patch_address, want.last_of_run,
                                            got.patch_address, got.last_of_run));
            end
         end
         // predict on each accepted word
         if (req_tvalid && req_tready) begin
            row  = row_checks.pop_front();
            base = pending_patches.size();
            n    = decode_entry(req_tdata, req_tlast);
            if (req_tdata[0] == WORD_BITMAP) begin
               bitmap_words++;
               if (n == 0) empty_bitmaps++;
            end else begin
               address_words++;
            end
            if (req_tlast) table_ends++;
            if (row.typed && (n != int'(row.count) ||
                              (n > 0 && pending_patches[base].patch_address !== row.first)))
               report_mismatch("directed row",
                               $sformatf("word %h: want %0d from %h, predicted %0d from %h",
                                         row.entry, row.count, row.first, n,
                                         (n > 0) ? pending_patches[base].patch_address
                                                 : '0));
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // drives one word and holds it until the transfer completes
   task automatic push_entry(input word_row_type row);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      row_checks.push_back(row);
      req_tvalid <= 1'b1;
      req_tdata  <= row.entry;
      req_tlast  <= row.end_of_table;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // bitmap words of varied density, bit 0 always set
   function automatic logic [63:0] rand_bitmap();
      logic [63:0] bits;
      case ($urandom_range(9))
         0, 1, 2, 3: bits = rand_word() & rand_word() & rand_word();
         4, 5:       bits = rand_word();
         6:          bits = 64'h1 << $urandom_range(63, 1);
         7:          bits = '0;
         8:          bits = ~64'h0 << $urandom_range(63, 32);
         default:    bits = ~64'h0;
      endcase
      return bits | 64'h1;
   endfunction

   // well-formed tables (address then bitmaps) with some stray words mixed in
   task automatic run_tables(input int target);
      word_row_type row;
      logic [63:0]  addr;
      int           runs;
      int           stop;
      stop = words_sent + target;
      row  = '0;
      while (words_sent < stop) begin
         if ($urandom_range(9) == 0) begin
            row.entry        = ($urandom_range(1) == 0) ? rand_word() : rand_bitmap();
            row.end_of_table = ($urandom_range(3) == 0);
            push_entry(row);
         end else begin
            addr = rand_word();
            if ($urandom_range(3) == 0) addr[63:16] = '1;
            addr[0]          = WORD_ADDRESS;
            row.entry        = addr;
            runs             = $urandom_range(4);
            row.end_of_table = (runs == 0) && ($urandom_range(2) == 0);
            push_entry(row);
            for (int k = 0; k < runs; k++) begin
               row.entry        = rand_bitmap();
               row.end_of_table = (k == runs - 1) && ($urandom_range(2) == 0);
               push_entry(row);
            end
         end
      end
   endtask

   // step past the current edge first so the last accepted word is already predicted
   task automatic wait_drained();
      @(posedge clock);
      while (pending_patches.size() != 0) @(posedge clock);
   endtask

   // stimulus and end of run
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows from reset, no idling
      foreach (DIRECTED_ROWS[i]) push_entry(DIRECTED_ROWS[i]);
      req_tvalid <= 1'b0;
      wait_drained();

      // random tables under each idle and stall mix; sender holds off until drained
      run_tables(PHASE_WORDS);
      req_tvalid <= 1'b0;
      wait_drained();
      idle_pct  = 84;
      stall_pct = 0;
      run_tables(PHASE_WORDS);
      req_tvalid <= 1'b0;
      wait_drained();
      idle_pct  = 0;
      stall_pct = 84;
      run_tables(PHASE_WORDS);
      req_tvalid <= 1'b0;
      wait_drained();
      idle_pct  = 26;
      stall_pct = 26;
      run_tables(PHASE_WORDS);
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (100) @(posedge clock);
      if (pending_patches.size() != 0)
         report_mismatch("end of run", $sformatf("%0d patch addresses never came",
                                                 pending_patches.size()));
      $display("decoded %0d table words: %0d address, %0d bitmap (%0d empty), %0d table ends",
               words_sent, address_words, bitmap_words, empty_bitmaps, table_ends);
      $display("checked %0d patch addresses under four idle/stall mixes, %0d mismatches",
               patches_checked, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* relr_relocation_decoder_top.f */
design/relr_pkg.sv
design/relr_front.sv
design/relr_cmd_queue.sv
design/relr_back.sv
design/relr_relocation_decoder_top.sv
tb/relr_relocation_decoder_top_tb.sv
